// ----- sv/sqb_pkg.sv -----
package sqb_pkg;

    typedef enum logic [3:0] {
        t_ST_IDLE,
        t_ST_LOOKUP,
        t_ST_PIVOT,
        t_ST_SINE,
        t_ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic flush;
        logic lookup_clr;
        logic lookup_step;
        logic alloc;
        logic pivot;
        logic sine_step;
        logic emit_load;
    } t_cmd;

    typedef struct packed {
        logic need_flush;
        logic lookup_done;
        logic found;
        logic sine_done;
        logic out_busy;
        logic last_corner;
        logic out_take;
    } t_status;

endpackage

// ----- sv/sqb_ctrl.sv -----
module sqb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  sqb_pkg::t_status  i_sts,
    output sqb_pkg::t_cmd     o_cmd
);

    sqb_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sqb_pkg::t_ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            sqb_pkg::t_ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load       = 1'b1;
                    o_cmd.lookup_clr = 1'b1;
                    n_state          = sqb_pkg::t_ST_LOOKUP;
                end
            end
            sqb_pkg::t_ST_LOOKUP: begin
                if (i_sts.need_flush) begin
                    o_cmd.flush = 1'b1;
                end else if (i_sts.found || i_sts.lookup_done) begin
                    o_cmd.alloc = 1'b1;
                    n_state     = sqb_pkg::t_ST_PIVOT;
                end else begin
                    o_cmd.lookup_step = 1'b1;
                end
            end
            sqb_pkg::t_ST_PIVOT: begin
                o_cmd.pivot = 1'b1;
                n_state     = sqb_pkg::t_ST_SINE;
            end
            sqb_pkg::t_ST_SINE: begin
                if (i_sts.sine_done) begin
                    if (!i_sts.out_busy) begin
                        o_cmd.emit_load = 1'b1;
                        n_state         = sqb_pkg::t_ST_EMIT;
                    end
                end else begin
                    o_cmd.sine_step = 1'b1;
                end
            end
            sqb_pkg::t_ST_EMIT: begin
                if (i_sts.out_take && i_sts.last_corner) begin
                    n_state = sqb_pkg::t_ST_IDLE;
                end
            end
            default: n_state = sqb_pkg::t_ST_IDLE;
        endcase
    end

endmodule

// ----- sv/sqb_dp.sv -----
module sqb_dp #(
    parameter int MAX_SLOTS   = 32,
    parameter int BATCH_QUADS = 1024,
    parameter int SINE_BITS   = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sqb_pkg::t_cmd       i_cmd,
    output sqb_pkg::t_status    o_sts,
    input  logic                i_cfg_valid,
    input  logic [5:0]          i_cfg_data,
    input  logic [31:0]         i_texture_id,
    input  logic [16:0]         i_src_u0,
    input  logic [16:0]         i_src_v0,
    input  logic [16:0]         i_src_u1,
    input  logic [16:0]         i_src_v1,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic signed [31:0]  i_size_x,
    input  logic signed [31:0]  i_size_y,
    input  logic [15:0]         i_angle,
    input  logic signed [15:0]  i_pivot_dx,
    input  logic signed [15:0]  i_pivot_dy,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_vert_x,
    output logic signed [31:0]  o_vert_y,
    output logic [16:0]         o_tex_u,
    output logic [16:0]         o_tex_v,
    output logic [4:0]          o_tex_slot,
    output logic [9:0]          o_quad_index,
    output logic [1:0]          o_corner,
    output logic                o_flush_before,
    output logic [10:0]         o_flushed_quads,
    output logic                o_last
);

    localparam int SW = $clog2(MAX_SLOTS + 1);
    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int BW = $clog2(BATCH_QUADS + 1);
    localparam int SH = 16 - SINE_BITS;

    logic [31:0] r_tags [MAX_SLOTS];
    logic [5:0]  r_max;
    logic [SW-1:0] r_slot_cnt;
    logic [BW-1:0] r_batch_cnt;
    logic [SW-1:0] r_idx;
    logic [SW-1:0] r_slot;
    logic [BW-1:0] r_quad;
    logic        r_flushed;
    logic [BW-1:0] r_flushed_n;

    logic [31:0] r_tex;
    logic [16:0] r_u0, r_v0, r_u1, r_v1;
    logic signed [31:0] r_px, r_py, r_sx, r_sy;
    logic [15:0] r_ang;
    logic signed [15:0] r_pdx, r_pdy;

    logic signed [33:0] r_cx, r_cy;
    logic signed [17:0] r_sn, r_cs;
    logic [2:0]  r_sstep;
    logic [16:0] r_x2a, r_x3a, r_x2b, r_x3b;
    logic [16:0] r_sa, r_sb;

    logic [1:0]  r_k;
    logic        r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= 6'd32;
        end else if (i_cfg_valid) begin
            r_max <= i_cfg_data;
        end
    end

    logic [6:0] w_lim;
    assign w_lim = ({1'b0, r_max} < 7'(MAX_SLOTS)) ? {1'b0, r_max} : 7'(MAX_SLOTS);
    assign o_sts.need_flush  = (r_idx == '0) && !r_flushed &&
        ((7'(r_slot_cnt) >= w_lim) || (r_batch_cnt >= BW'(BATCH_QUADS)));
    assign o_sts.lookup_done = (r_idx >= r_slot_cnt);
    assign o_sts.found       = !o_sts.lookup_done && (r_tags[r_idx[IW-1:0]] == r_tex);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_cnt  <= '0;
            r_batch_cnt <= '0;
        end else if (i_cmd.flush) begin
            r_slot_cnt  <= '0;
            r_batch_cnt <= '0;
        end else if (i_cmd.alloc) begin
            r_batch_cnt <= r_batch_cnt + 1'b1;
            if (!o_sts.found) r_slot_cnt <= r_slot_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tex <= i_texture_id; r_u0 <= i_src_u0; r_v0 <= i_src_v0;
            r_u1 <= i_src_u1; r_v1 <= i_src_v1; r_px <= i_pos_x; r_py <= i_pos_y;
            r_sx <= i_size_x; r_sy <= i_size_y; r_ang <= i_angle;
            r_pdx <= i_pivot_dx; r_pdy <= i_pivot_dy;
        end
        if (i_cmd.lookup_clr) begin
            r_idx <= '0; r_flushed <= 1'b0; r_flushed_n <= '0;
        end
        if (i_cmd.flush) begin
            r_flushed <= 1'b1; r_flushed_n <= r_batch_cnt;
        end
        if (i_cmd.lookup_step) r_idx <= r_idx + 1'b1;
        if (i_cmd.alloc) begin
            r_quad <= r_batch_cnt;
            r_slot <= o_sts.found ? r_idx : r_slot_cnt;
            if (!o_sts.found && (r_slot_cnt < SW'(MAX_SLOTS)))
                r_tags[r_slot_cnt[IW-1:0]] <= r_tex;
        end
    end

    // pivot
    logic signed [16:0] w_fx, w_fy;
    logic signed [47:0] w_mx, w_my;
    assign w_fx = 17'sd8192 + 17'(r_pdx);
    assign w_fy = 17'sd8192 + 17'(r_pdy);
    assign w_mx = 48'(w_fx) * 48'(r_sx);
    assign w_my = 48'(w_fy) * 48'(r_sy);
    always_ff @(posedge i_clk) begin
        if (i_cmd.pivot) begin
            r_cx <= 34'(w_mx >>> 14);
            r_cy <= 34'(w_my >>> 14);
        end
    end

    // quarter sine of both arguments, in steps: squares, cubes, each polynomial, quadrant
    logic [15:0] w_ph;
    logic [16:0] w_xa, w_xb;
    assign w_ph = (r_ang >> SH) << SH;
    assign w_xa = {1'b0, w_ph[13:0], 2'b00};
    assign w_xb = 17'd65536 - w_xa;

    function automatic logic [16:0] f_mulq(input logic [16:0] a, input logic [16:0] b);
        logic [33:0] p;
        p = 34'(a) * 34'(b);
        return 17'(p >> 16);
    endfunction

    function automatic logic [16:0] f_poly(input logic [16:0] x, input logic [16:0] x3,
                                           input logic [16:0] x5);
        logic [40:0] s;
        s = 41'(41'd102944 * 41'(x)) + 41'(41'd4640 * 41'(x5)) - 41'(41'd42048 * 41'(x3));
        s = s >> 16;
        return (s > 41'd65536) ? 17'd65536 : 17'(s);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.pivot) begin
            r_sstep <= '0;
        end else if (i_cmd.sine_step) begin
            r_sstep <= r_sstep + 1'b1;
            case (r_sstep)
                3'd0: begin
                    r_x2a <= f_mulq(w_xa, w_xa); r_x2b <= f_mulq(w_xb, w_xb);
                end
                3'd1: begin
                    r_x3a <= f_mulq(r_x2a, w_xa); r_x3b <= f_mulq(r_x2b, w_xb);
                end
                3'd2: begin
                    r_sa <= f_poly(w_xa, r_x3a, f_mulq(r_x3a, r_x2a));
                end
                3'd3: begin
                    r_sb <= f_poly(w_xb, r_x3b, f_mulq(r_x3b, r_x2b));
                end
                default: begin
                    case (w_ph[15:14])
                        2'd0:    begin r_sn <= 18'(r_sa);  r_cs <= 18'(r_sb);  end
                        2'd1:    begin r_sn <= 18'(r_sb);  r_cs <= -18'(r_sa); end
                        2'd2:    begin r_sn <= -18'(r_sa); r_cs <= -18'(r_sb); end
                        default: begin r_sn <= -18'(r_sb); r_cs <= 18'(r_sa);  end
                    endcase
                end
            endcase
        end
    end
    assign o_sts.sine_done = (r_sstep == 3'd5);

    // vertex emission, one corner per cycle unless the output stalls
    logic [1:0]  w_k;
    logic        w_ca, w_cb;
    logic signed [33:0] w_dx, w_dy;
    logic signed [52:0] w_rx, w_ry;
    logic w_take;
    assign w_take = r_ov && !i_stall;
    assign w_k  = i_cmd.emit_load ? 2'd0 : r_k + 2'd1;
    assign w_ca = w_k[1];
    assign w_cb = (w_k == 2'd0) || (w_k == 2'd3);
    assign w_dx = (w_ca ? 34'(r_sx) : 34'sd0) - r_cx;
    assign w_dy = (w_cb ? 34'(r_sy) : 34'sd0) - r_cy;
    assign w_rx = (53'(r_cs) * 53'(w_dx) - 53'(r_sn) * 53'(w_dy)) >>> 16;
    assign w_ry = (53'(r_sn) * 53'(w_dx) + 53'(r_cs) * 53'(w_dy)) >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit_load || (w_take && r_k != 2'd3)) begin
            r_ov <= 1'b1;
        end else if (w_take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load || (w_take && r_k != 2'd3)) begin
            r_k             <= w_k;
            o_vert_x        <= 32'(34'(r_px) + r_cx + 34'(w_rx));
            o_vert_y        <= 32'(34'(r_py) + r_cy + 34'(w_ry));
            o_tex_u         <= w_ca ? r_u1 : r_u0;
            o_tex_v         <= w_cb ? r_v1 : r_v0;
            o_tex_slot      <= 5'(r_slot);
            o_quad_index    <= 10'(r_quad);
            o_flush_before  <= (w_k == 2'd0) && r_flushed;
            o_flushed_quads <= (w_k == 2'd0) ? 11'(r_flushed_n) : 11'd0;
        end
    end

    assign o_corner          = r_k;
    assign o_last            = (r_k == 2'd3);
    assign o_valid           = r_ov;
    assign o_sts.out_busy    = r_ov;
    assign o_sts.last_corner = (r_k == 2'd3);
    assign o_sts.out_take    = w_take;

endmodule

// ----- sv/sprite_quad_batcher.sv -----
// Sprite quad batcher: takes one sprite per item and returns its four quad
// vertices as four output items in corner order, rotated about the pivot.
// A sprite is taken only while the block is idle. It then compares the
// texture table entries in turn until a hit or until the slots in use are
// all compared, flushing first when the slots or the quad batch are full,
// then runs the pivot multiply and the quarter-sine unit and loads the
// first vertex. The vertices then follow one per cycle unless the output
// stalls, and the next sprite can be taken in the cycle after the fourth
// vertex leaves.
module sprite_quad_batcher #(
    parameter int MAX_SLOTS   = 32,
    parameter int BATCH_QUADS = 1024,
    parameter int SINE_BITS   = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [5:0]          i_cfg_max_slots,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [31:0]         i_texture_id,
    input  logic [16:0]         i_src_u0,
    input  logic [16:0]         i_src_v0,
    input  logic [16:0]         i_src_u1,
    input  logic [16:0]         i_src_v1,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic signed [31:0]  i_size_x,
    input  logic signed [31:0]  i_size_y,
    input  logic [15:0]         i_angle,
    input  logic signed [15:0]  i_pivot_dx,
    input  logic signed [15:0]  i_pivot_dy,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_vert_x,
    output logic signed [31:0]  o_vert_y,
    output logic [16:0]         o_tex_u,
    output logic [16:0]         o_tex_v,
    output logic [4:0]          o_tex_slot,
    output logic [9:0]          o_quad_index,
    output logic [1:0]          o_corner,
    output logic                o_flush_before,
    output logic [10:0]         o_flushed_quads,
    output logic                o_last
);

    sqb_pkg::t_cmd    w_cmd;
    sqb_pkg::t_status w_sts;

    assign o_cfg_ready = 1'b1;

    sqb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    sqb_dp #(
        .MAX_SLOTS   (MAX_SLOTS),
        .BATCH_QUADS (BATCH_QUADS),
        .SINE_BITS   (SINE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_max_slots),
        .i_texture_id    (i_texture_id),
        .i_src_u0        (i_src_u0),
        .i_src_v0        (i_src_v0),
        .i_src_u1        (i_src_u1),
        .i_src_v1        (i_src_v1),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_size_x        (i_size_x),
        .i_size_y        (i_size_y),
        .i_angle         (i_angle),
        .i_pivot_dx      (i_pivot_dx),
        .i_pivot_dy      (i_pivot_dy),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_vert_x        (o_vert_x),
        .o_vert_y        (o_vert_y),
        .o_tex_u         (o_tex_u),
        .o_tex_v         (o_tex_v),
        .o_tex_slot      (o_tex_slot),
        .o_quad_index    (o_quad_index),
        .o_corner        (o_corner),
        .o_flush_before  (o_flush_before),
        .o_flushed_quads (o_flushed_quads),
        .o_last          (o_last)
    );

endmodule

// ----- sv/sqb_checker.sv -----
module sqb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_corner,
    input logic        o_last,
    input logic        o_flush_before,
    input logic [10:0] o_flushed_quads
);

    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_corner == 2'd3)))
        else $error("last flag mismatch");

    a_flush_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_corner != 2'd0) |-> (!o_flush_before && o_flushed_quads == 11'd0))
        else $error("flush info off first corner");

    a_corner_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_corner != 2'd3) |=>
            (o_valid && o_corner == $past(o_corner) + 2'd1))
        else $error("corner sequence broken");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_corner)))
        else $error("stalled item changed");

endmodule

bind sprite_quad_batcher sqb_checker u_sqb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_corner        (o_corner),
    .o_last          (o_last),
    .o_flush_before  (o_flush_before),
    .o_flushed_quads (o_flushed_quads)
);
